// ----- rtl/core/mmc_bce_pkg.sv -----
package mmc_bce_pkg;

  // default geometry
  localparam int unsigned NUM_BLOCKS_DEF  = 2048;
  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned WORD_BYTES_DEF  = 8;

  // payload widths
  localparam int unsigned OPC_W    = 6;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 32;

  // command indexes
  localparam logic [OPC_W-1:0] OP_READ_SINGLE  = 6'd17;
  localparam logic [OPC_W-1:0] OP_READ_MULTI   = 6'd18;
  localparam logic [OPC_W-1:0] OP_WRITE_SINGLE = 6'd24;
  localparam logic [OPC_W-1:0] OP_WRITE_MULTI  = 6'd25;

  // R1 response bits
  localparam logic [STATUS_W-1:0] R1_RANGE_ERR   = 32'h8000_0000;
  localparam logic [STATUS_W-1:0] R1_ADDR_ERR    = 32'h4000_0000;
  localparam logic [STATUS_W-1:0] R1_LEN_ERR     = 32'h2000_0000;
  localparam logic [STATUS_W-1:0] R1_BAD_CMD     = 32'h0040_0000;
  localparam logic [STATUS_W-1:0] R1_DATA_READY  = 32'h0000_0100;
  localparam logic [STATUS_W-1:0] R1_ERROR_MASK  = 32'hFFF9_A000;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [ADDR_W-1:0] byte_address;
    logic [CNT_W-1:0]  block_count;
  } cmd_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                start;     // command clean, open a transfer
    logic                is_write;
  } cmd_res_t;

endpackage

// ----- rtl/core/mmc_bce_req_if.sv -----
interface mmc_bce_req_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [mmc_bce_pkg::OPC_W-1:0]     opcode;
  logic [mmc_bce_pkg::ADDR_W-1:0]    byte_address;
  logic [mmc_bce_pkg::CNT_W-1:0]     block_count;
  logic [mmc_bce_pkg::DATA_W-1:0]    data_in;

  modport source (output valid, operation, opcode, byte_address, block_count, data_in,
                  input ready);
  modport sink   (input valid, operation, opcode, byte_address, block_count, data_in,
                  output ready);
endinterface

// ----- rtl/core/mmc_bce_rsp_if.sv -----
interface mmc_bce_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mmc_bce_pkg::STATUS_W-1:0]  status;
  logic [mmc_bce_pkg::DATA_W-1:0]    data_out;
  logic                              last_word;
  logic                              no_transfer;

  modport source (output valid, status, data_out, last_word, no_transfer, input ready);
  modport sink   (input valid, status, data_out, last_word, no_transfer, output ready);
endinterface

// ----- rtl/core/mmc_bce_cmd_check.sv -----
module mmc_bce_cmd_check #(
  parameter int unsigned NUM_BLOCKS  = mmc_bce_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = mmc_bce_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned WORD_BYTES  = mmc_bce_pkg::WORD_BYTES_DEF,
  localparam int unsigned WPB         = BLOCK_BYTES / WORD_BYTES,
  localparam int unsigned STORE_WORDS = NUM_BLOCKS * WPB,
  localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1,
  localparam int unsigned LW          = $clog2(STORE_WORDS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mmc_bce_pkg::cmd_req_t req,
  input  logic                  ack,
  output logic                  done,
  output mmc_bce_pkg::cmd_res_t res,
  output logic [AW-1:0]         ptr,
  output logic [LW-1:0]         total
);

  localparam int unsigned AD_W    = mmc_bce_pkg::ADDR_W;
  localparam int unsigned CN_W    = mmc_bce_pkg::CNT_W;
  localparam bit          BB_POW2 = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;
  localparam int unsigned BB_LOG  = $clog2(BLOCK_BYTES);
  localparam int unsigned FB_W    = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned WPB_W   = $clog2(WPB + 1);
  localparam int unsigned PW      = FB_W + WPB_W;
  localparam int unsigned TW      = CN_W + WPB_W;
  localparam int unsigned MW      = 2 * AD_W;
  localparam logic [AD_W-1:0] ADDR_MASK = AD_W'(BLOCK_BYTES - 1);
  localparam logic [AD_W-1:0] BB_CONST  = AD_W'(BLOCK_BYTES);
  // reciprocal of the block size: q = (t + ((n - t) >> 1)) >> (BB_LOG - 1),
  // t = upper half of n * RCP
  localparam longint unsigned RCP_FULL =
    ((64'd1 << AD_W) * ((64'd1 << BB_LOG) - 64'(BLOCK_BYTES))) / 64'(BLOCK_BYTES) + 64'd1;
  localparam logic [AD_W-1:0] RCP = AD_W'(RCP_FULL);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_QUO   = 3'd2;
  localparam logic [2:0] ST_REM   = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                      state;
  logic [mmc_bce_pkg::OPC_W-1:0]   opc;
  logic [AD_W-1:0]                 addr;
  logic [CN_W-1:0]                 count;
  logic [AD_W-1:0]                 quo;
  logic [MW-1:0]                   prod;
  logic                            addr_err;

  // block index from the reciprocal product
  logic [AD_W-1:0] prod_hi;
  logic [AD_W-1:0] quo_next;

  assign prod_hi  = prod[MW-1:AD_W];
  assign quo_next = (prod_hi + ((addr - prod_hi) >> 1)) >> (BB_LOG - 1);

  // error checks
  logic                               single, multi, len_err, range_err;
  logic [mmc_bce_pkg::STATUS_W-1:0]   status_next;
  logic [PW-1:0]                      ptr_prod;
  logic [TW-1:0]                      tot_prod;

  always_comb begin
    single    = (opc == mmc_bce_pkg::OP_READ_SINGLE) || (opc == mmc_bce_pkg::OP_WRITE_SINGLE);
    multi     = (opc == mmc_bce_pkg::OP_READ_MULTI) || (opc == mmc_bce_pkg::OP_WRITE_MULTI);
    len_err   = single ? (count != CN_W'(1)) : (count <= CN_W'(1));
    range_err = single ? ({1'b0, quo} >= (AD_W + 1)'(NUM_BLOCKS))
                       : (({1'b0, quo} + (AD_W + 1)'(count)) > (AD_W + 1)'(NUM_BLOCKS));
    status_next = mmc_bce_pkg::R1_DATA_READY;
    if (single || multi) begin
      if (len_err)   status_next = status_next | mmc_bce_pkg::R1_LEN_ERR;
      if (addr_err)  status_next = status_next | mmc_bce_pkg::R1_ADDR_ERR;
      if (range_err) status_next = status_next | mmc_bce_pkg::R1_RANGE_ERR;
    end else begin
      status_next = status_next | mmc_bce_pkg::R1_BAD_CMD;
    end
  end

  assign ptr_prod = PW'(quo[FB_W-1:0]) * PW'(WPB);
  assign tot_prod = TW'(count) * TW'(WPB);
  assign done     = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) state <= BB_POW2 ? ST_CHECK : ST_MUL;
        end
        ST_MUL:   state <= ST_QUO;
        ST_QUO:   state <= ST_REM;
        ST_REM:   state <= ST_CHECK;
        ST_CHECK: state <= ST_DONE;
        ST_DONE: begin
          if (ack) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          opc   <= req.opcode;
          count <= req.block_count;
          addr  <= req.byte_address;
          if (BB_POW2) begin
            quo      <= req.byte_address >> BB_LOG;
            addr_err <= (req.byte_address & ADDR_MASK) != '0;
          end else begin
            quo      <= '0;
            addr_err <= 1'b0;
          end
        end
      end
      ST_MUL: begin
        prod <= MW'(RCP) * MW'(addr);
      end
      ST_QUO: begin
        quo <= quo_next;
      end
      ST_REM: begin
        addr_err <= addr != (quo * BB_CONST);
      end
      ST_CHECK: begin
        res.status   <= status_next;
        res.start    <= (single || multi) && ((status_next & mmc_bce_pkg::R1_ERROR_MASK) == '0);
        res.is_write <= (opc == mmc_bce_pkg::OP_WRITE_SINGLE)
                     || (opc == mmc_bce_pkg::OP_WRITE_MULTI);
        ptr          <= ptr_prod[AW-1:0];
        total        <= tot_prod[LW-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/mmc_block_command_engine.sv -----
// Data requests: one per cycle unless a command, the clearing sweep or a stalled response
// holds the port; the response passes the store read port, then the output register.
// Command requests: checked at once for a power-of-two block size, otherwise after the
// reciprocal multiply, quotient and remainder steps; no request is taken until the command
// status is handed on. Reset: synchronous; afterwards the store is zeroed one word per
// cycle, all STORE_WORDS words (131072 by default), taking no request.
module mmc_block_command_engine #(
  parameter int unsigned NUM_BLOCKS  = mmc_bce_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = mmc_bce_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned WORD_BYTES  = mmc_bce_pkg::WORD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mmc_bce_req_if.sink          req,
  mmc_bce_rsp_if.source        rsp
);

  localparam int unsigned WPB         = BLOCK_BYTES / WORD_BYTES;
  localparam int unsigned STORE_WORDS = NUM_BLOCKS * WPB;
  localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned LW          = $clog2(STORE_WORDS + 1);
  localparam int unsigned WORD_W      = WORD_BYTES * 8;
  localparam int unsigned DW          = mmc_bce_pkg::DATA_W;
  localparam int unsigned SW          = mmc_bce_pkg::STATUS_W;

  // ---------------------------------------------------------------------------------
  // Block store: one write port, one registered read port.
  // ---------------------------------------------------------------------------------
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] mem_q;

  // post-reset clearing sweep
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // transfer context
  logic          active;
  logic          is_write;
  logic [AW-1:0] ptr;
  logic [LW-1:0] left;

  // command unit handshake
  logic                  cmd_busy;
  logic                  cmd_start;
  logic                  cmd_done;
  logic                  cmd_ack;
  mmc_bce_pkg::cmd_req_t cmd_req;
  mmc_bce_pkg::cmd_res_t cmd_res;
  logic [AW-1:0]         cmd_ptr;
  logic [LW-1:0]         cmd_total;

  // pending stage: response waiting for the read word, then the output register
  logic          p_valid;
  logic [SW-1:0] p_status;
  logic          p_rd;
  logic          p_last;
  logic          p_none;

  logic          o_valid;
  logic [SW-1:0] o_status;
  logic [DW-1:0] o_data;
  logic          o_last;
  logic          o_none;

  logic out_free, p_move, p_free, acc, acc_data, p_load, do_wr, do_rd;

  assign out_free  = !o_valid || rsp.ready;
  assign p_move    = p_valid && out_free;
  assign p_free    = !p_valid || out_free;
  // Only accept when the pending slot frees up this cycle, so mem_q stays with its request.
  assign req.ready = !clr_busy && !cmd_busy && p_free;
  assign acc       = req.valid && req.ready;
  assign acc_data  = acc && req.operation;
  assign cmd_start = acc && !req.operation;
  assign cmd_ack   = cmd_done && p_free;
  assign p_load    = acc_data || cmd_ack;
  assign do_wr     = acc_data && active && is_write;
  assign do_rd     = acc_data && active && !is_write;

  assign cmd_req.opcode       = req.opcode;
  assign cmd_req.byte_address = req.byte_address;
  assign cmd_req.block_count  = req.block_count;

  mmc_bce_cmd_check #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .WORD_BYTES  (WORD_BYTES)
  ) u_cmd (
    .clk   (clk),
    .rst   (rst),
    .start (cmd_start),
    .req   (cmd_req),
    .ack   (cmd_ack),
    .done  (cmd_done),
    .res   (cmd_res),
    .ptr   (cmd_ptr),
    .total (cmd_total)
  );

  // store port: sweep writes zeros, write transfers store the low word bytes
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (do_wr) begin
      mem[ptr] <= req.data_in[WORD_W-1:0];
    end
    if (do_rd) mem_q <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(STORE_WORDS - 1)) clr_busy <= 1'b0;
    end
  end

  // Transfer context. Every command closes the open transfer; a clean one reopens it
  // when its status is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      is_write <= 1'b0;
      ptr      <= '0;
      left     <= '0;
      cmd_busy <= 1'b0;
    end else begin
      if (cmd_start) begin
        cmd_busy <= 1'b1;
        active   <= 1'b0;
        left     <= '0;
      end
      if (cmd_ack) begin
        cmd_busy <= 1'b0;
        if (cmd_res.start) begin
          active   <= cmd_total != '0;
          is_write <= cmd_res.is_write;
          ptr      <= cmd_ptr;
          left     <= cmd_total;
        end
      end
      if (acc_data && active) begin
        ptr  <= ptr + AW'(1);
        left <= left - LW'(1);
        if (left == LW'(1)) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_status <= cmd_ack ? cmd_res.status : '0;
      p_rd     <= do_rd;
      p_last   <= acc_data && active && (left == LW'(1));
      p_none   <= acc_data && !active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_move) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_status <= p_status;
      o_data   <= p_rd ? DW'(mem_q) : '0;
      o_last   <= p_last;
      o_none   <= p_none;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.data_out    = o_data;
  assign rsp.last_word   = o_last;
  assign rsp.no_transfer = o_none;

endmodule

// ----- rtl/core/mmc_bce_chk.sv -----
module mmc_bce_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [mmc_bce_pkg::STATUS_W-1:0]   status,
  input logic [mmc_bce_pkg::DATA_W-1:0]     data_out,
  input logic                               last_word,
  input logic                               no_transfer
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out)
      && $stable(last_word) && $stable(no_transfer))
    else $error("response changed while stalled");

  // a stray data request carries nothing else
  a_stray: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && no_transfer |-> status == '0 && data_out == '0 && !last_word)
    else $error("no_transfer response not clean");

  // command responses always show ready-for-data and no data fields
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != '0 |->
      (status & mmc_bce_pkg::R1_DATA_READY) != '0 && data_out == '0
      && !last_word && !no_transfer)
    else $error("malformed command response");

  // right after reset, as the store sweep starts: nothing accepted, nothing shown
  a_reset: assert property (@(posedge clk) rst |=> !req_ready && !rsp_valid)
    else $error("activity right after reset");

endmodule

bind mmc_block_command_engine mmc_bce_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .data_out    (rsp.data_out),
  .last_word   (rsp.last_word),
  .no_transfer (rsp.no_transfer)
);
